// File: sv/hid_gamepad_report_decoder_macros.svh
// Assertion helpers for the HID gamepad decoder.
// Each macro expects clk and arst_n to be visible in the calling module.
`ifndef HID_GAMEPAD_REPORT_DECODER_MACROS_SVH
`define HID_GAMEPAD_REPORT_DECODER_MACROS_SVH

// Same-cycle implication
`define HGRD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define HGRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/hgrd_pkg.sv
package hgrd_pkg;

	// NES mask bits
	localparam logic [7:0] DIR_UP    = 8'h10;
	localparam logic [7:0] DIR_DOWN  = 8'h20;
	localparam logic [7:0] DIR_LEFT  = 8'h40;
	localparam logic [7:0] DIR_RIGHT = 8'h80;

	// Axis deadzone: below 128-64 or above 128+64 is a direction
	localparam logic [7:0] AXIS_LO = 8'd64;
	localparam logic [7:0] AXIS_HI = 8'd192;

	localparam logic [7:0] ANY_ID = 8'hFF;

	// Byte counter saturates at 256
	localparam int CNT_W = 9;
	localparam logic [CNT_W-1:0] CNT_MAX = 9'd256;

	// D-pad modes
	localparam logic [1:0] MODE_AXIS = 2'd0;
	localparam logic [1:0] MODE_HAT  = 2'd1;
	localparam logic [1:0] MODE_DBIT = 2'd2;

	// Register map, index = paddr[5:3]
	localparam int ADDR_W = 6;
	localparam logic [2:0] REG_DPAD_MODE   = 3'd0;
	localparam logic [2:0] REG_DPAD_OFFSET = 3'd1;
	localparam logic [2:0] REG_X_OFFSET    = 3'd2;
	localparam logic [2:0] REG_Y_OFFSET    = 3'd3;
	localparam logic [2:0] REG_BTN_OFFSET  = 3'd4;
	localparam logic [2:0] REG_MAP_LOW     = 3'd5;
	localparam logic [2:0] REG_MAP_HIGH    = 3'd6;
	localparam logic [2:0] REG_ID_FILTER   = 3'd7;

	typedef struct packed {
		logic [1:0]  dpad_mode;
		logic [3:0]  dpad_offset;
		logic [7:0]  x_offset;
		logic [7:0]  y_offset;
		logic [3:0]  button_offset;
		logic [63:0] button_map_low;
		logic [63:0] button_map_high;
		logic [7:0]  id_filter;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] pad_bits;
		logic       changed;
		logic       accepted;
	} res_t;

	// Hat switch: 0..7 clockwise from up, anything else centered
	function automatic logic [7:0] hat_dir(input logic [3:0] h);
		logic [7:0] d;
		case (h)
			4'd0: d = DIR_UP;
			4'd1: d = DIR_UP | DIR_RIGHT;
			4'd2: d = DIR_RIGHT;
			4'd3: d = DIR_DOWN | DIR_RIGHT;
			4'd4: d = DIR_DOWN;
			4'd5: d = DIR_DOWN | DIR_LEFT;
			4'd6: d = DIR_LEFT;
			4'd7: d = DIR_UP | DIR_LEFT;
			default: d = 8'h00;
		endcase
		return d;
	endfunction

endpackage

// File: sv/hgrd_cfg.sv
module hgrd_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [hgrd_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]               pwdata,
	output logic [63:0]               prdata,
	output logic                      pready,
	output hgrd_pkg::cfg_t            cfg
);
	import hgrd_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign idx = paddr[ADDR_W-1:3];
	assign cfg = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dpad_mode       <= MODE_HAT;
			cfg_q.dpad_offset     <= 4'd1;
			cfg_q.x_offset        <= 8'd0;
			cfg_q.y_offset        <= 8'd0;
			cfg_q.button_offset   <= 4'd2;
			cfg_q.button_map_low  <= 64'h0000_0000_0202_0104;
			cfg_q.button_map_high <= 64'h0000_0000_0800_0000;
			cfg_q.id_filter       <= ANY_ID;
		end else if (wr_en) begin
			case (idx)
				REG_DPAD_MODE:   cfg_q.dpad_mode       <= pwdata[1:0];
				REG_DPAD_OFFSET: cfg_q.dpad_offset     <= pwdata[3:0];
				REG_X_OFFSET:    cfg_q.x_offset        <= pwdata[7:0];
				REG_Y_OFFSET:    cfg_q.y_offset        <= pwdata[7:0];
				REG_BTN_OFFSET:  cfg_q.button_offset   <= pwdata[3:0];
				REG_MAP_LOW:     cfg_q.button_map_low  <= pwdata;
				REG_MAP_HIGH:    cfg_q.button_map_high <= pwdata;
				REG_ID_FILTER:   cfg_q.id_filter       <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Readback
	always_comb begin
		case (idx)
			REG_DPAD_MODE:   prdata = {62'd0, cfg_q.dpad_mode};
			REG_DPAD_OFFSET: prdata = {60'd0, cfg_q.dpad_offset};
			REG_X_OFFSET:    prdata = {56'd0, cfg_q.x_offset};
			REG_Y_OFFSET:    prdata = {56'd0, cfg_q.y_offset};
			REG_BTN_OFFSET:  prdata = {60'd0, cfg_q.button_offset};
			REG_MAP_LOW:     prdata = cfg_q.button_map_low;
			REG_MAP_HIGH:    prdata = cfg_q.button_map_high;
			REG_ID_FILTER:   prdata = {56'd0, cfg_q.id_filter};
			default:         prdata = 64'd0;
		endcase
	end

endmodule

// File: sv/hgrd_core.sv
`include "hid_gamepad_report_decoder_macros.svh"

module hgrd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  hgrd_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           in_action,
	input  logic [7:0]     in_data,
	input  logic [7:0]     in_rid,
	input  logic           in_last,
	input  logic           out_free,
	output hgrd_pkg::res_t res
);
	import hgrd_pkg::*;

	// Input register
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] data_s1;
	logic [7:0] rid_s1;
	logic       last_s1;

	// Report state
	logic [CNT_W-1:0] cnt_q;
	logic [7:0] pad_q;
	logic [7:0] cap_x_q, cap_y_q, cap_dpad_q, cap_blo_q, cap_bhi_q;

	logic has_res, proc;
	logic [CNT_W-1:0] pos, len;
	logic [4:0] bo_next;
	logic hit_x, hit_y, hit_dpad, hit_blo, hit_bhi;
	logic [7:0] x_eff, y_eff, dpad_eff, blo_eff, bhi_eff;
	logic [7:0] dir_bits, btn_bits, bits;
	logic id_ok;

	assign has_res = ~action_s1 & last_s1;
	assign proc = valid_s1 & (~has_res | out_free);
	assign in_ready = ~valid_s1 | proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid & in_ready) begin
			action_s1 <= in_action;
			data_s1   <= in_data;
			rid_s1    <= in_rid;
			last_s1   <= in_last;
		end
	end

	// Position match; the current byte bypasses the capture registers
	assign pos = cnt_q;
	assign bo_next = {1'b0, cfg.button_offset} + 5'd1;
	assign hit_x    = (pos == {1'b0, cfg.x_offset});
	assign hit_y    = (pos == {1'b0, cfg.y_offset});
	assign hit_dpad = (pos == {5'd0, cfg.dpad_offset});
	assign hit_blo  = (pos == {5'd0, cfg.button_offset});
	assign hit_bhi  = (pos == {4'd0, bo_next});

	assign x_eff    = hit_x    ? data_s1 : cap_x_q;
	assign y_eff    = hit_y    ? data_s1 : cap_y_q;
	assign dpad_eff = hit_dpad ? data_s1 : cap_dpad_q;
	assign blo_eff  = hit_blo  ? data_s1 : cap_blo_q;
	assign bhi_eff  = hit_bhi  ? data_s1 : cap_bhi_q;

	// Length including this byte, saturating
	assign len = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 9'd1;

	// Direction decode
	always_comb begin
		dir_bits = 8'h00;
		case (cfg.dpad_mode)
			MODE_AXIS: begin
				if (len > {1'b0, cfg.x_offset} && len > {1'b0, cfg.y_offset}) begin
					if (x_eff < AXIS_LO) dir_bits = dir_bits | DIR_LEFT;
					if (x_eff > AXIS_HI) dir_bits = dir_bits | DIR_RIGHT;
					if (y_eff < AXIS_LO) dir_bits = dir_bits | DIR_UP;
					if (y_eff > AXIS_HI) dir_bits = dir_bits | DIR_DOWN;
				end
			end
			MODE_HAT: begin
				if (len > {5'd0, cfg.dpad_offset}) dir_bits = hat_dir(dpad_eff[3:0]);
			end
			MODE_DBIT: begin
				// up, down, left, right sit in the top nibble in that order
				if (len > {5'd0, cfg.dpad_offset}) dir_bits = {dpad_eff[3:0], 4'h0};
			end
			default: dir_bits = 8'h00;
		endcase
	end

	// Button map: each pressed button ORs in its map byte
	always_comb begin
		btn_bits = 8'h00;
		if (len > {4'd0, bo_next}) begin
			for (int i = 0; i < 8; i++) begin
				if (blo_eff[i]) btn_bits = btn_bits | cfg.button_map_low[8*i +: 8];
				if (bhi_eff[i]) btn_bits = btn_bits | cfg.button_map_high[8*i +: 8];
			end
		end
	end

	assign bits  = dir_bits | btn_bits;
	assign id_ok = (cfg.id_filter == ANY_ID) || (rid_s1 == cfg.id_filter);

	assign res.valid    = proc & has_res;
	assign res.pad_bits = id_ok ? bits : pad_q;
	assign res.changed  = id_ok & (bits != pad_q);
	assign res.accepted = id_ok;

	// Counter and pad state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pad_q <= 8'h00;
		end else if (proc) begin
			if (action_s1) begin
				cnt_q <= '0;
				pad_q <= 8'h00;
			end else begin
				cnt_q <= last_s1 ? '0 : len;
				if (last_s1 && id_ok) pad_q <= bits;
			end
		end
	end

	// Captured bytes
	always_ff @(posedge clk) begin
		if (proc && !action_s1) begin
			if (hit_x)    cap_x_q    <= data_s1;
			if (hit_y)    cap_y_q    <= data_s1;
			if (hit_dpad) cap_dpad_q <= data_s1;
			if (hit_blo)  cap_blo_q  <= data_s1;
			if (hit_bhi)  cap_bhi_q  <= data_s1;
		end
	end

	`HGRD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_MAX, "byte count past saturation")
	`HGRD_ASSERT_NEXT(a_last_clears, proc && !action_s1 && last_s1, cnt_q == '0, "count kept")
	`HGRD_ASSERT_NEXT(a_conn_clears, proc && action_s1, cnt_q == '0 && pad_q == 8'h00, "no clear")

endmodule

// File: sv/hid_gamepad_report_decoder.sv
// An input item is held in the input register, decoded out of it, and its result is
// held in the result register on the master side.
// Throughput: one item per cycle; only a stalled result holds back report-ending items.
// Reset (arst_n low): registers return to defaults, byte count and pad state clear,
// no result pending.
`include "hid_gamepad_report_decoder_macros.svh"

module hid_gamepad_report_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hgrd_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	// Report bytes in
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,  // [7:0] data byte, [15:8] report ID
	input  logic                        s_axis_tlast,  // last_byte
	input  logic                        s_axis_tuser,  // [0] action
	// Button mask out
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,  // [7:0] pad_bits
	output logic [1:0]                  m_axis_tuser   // [0] changed, [1] accepted
);
	import hgrd_pkg::*;

	cfg_t cfg;
	res_t res;

	logic       out_valid_q;
	logic [7:0] out_bits_q;
	logic       out_changed_q;
	logic       out_accepted_q;
	logic       out_free;

	hgrd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hgrd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_data   (s_axis_tdata[7:0]),
		.in_rid    (s_axis_tdata[15:8]),
		.in_last   (s_axis_tlast),
		.out_free  (out_free),
		.res       (res)
	);

	// Result register
	assign out_free = ~out_valid_q | m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			out_bits_q     <= res.pad_bits;
			out_changed_q  <= res.changed;
			out_accepted_q <= res.accepted;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_bits_q;
	assign m_axis_tuser  = {out_accepted_q, out_changed_q};

	`HGRD_ASSERT_NOW(a_reject_flag, out_valid_q && !out_accepted_q, !out_changed_q, "reject changed")
	`HGRD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
	`HGRD_ASSERT_NEXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "data moved")

endmodule

// File: tb/sv/hid_gamepad_report_decoder_tb.sv
`timescale 1ns / 1ps

module hid_gamepad_report_decoder_tb;
	import hgrd_pkg::*;

	// mode 3 is not a real layout: buttons only
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int PHASES = 16;
	localparam int CALM_FROM = 13;
	localparam int PHASE_ITEMS = 50;

	typedef struct packed {
		logic       action;
		logic [7:0] data;
		logic [7:0] rid;
		logic       last;
	} hid_byte_t;

	typedef struct packed {
		logic [7:0] pad_bits;
		logic       changed;
		logic       accepted;
	} pad_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [7:0] data byte, [15:8] report ID
	logic        s_axis_tlast = 1'b0;
	logic        s_axis_tuser = 1'b0;  // [0] action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;  // [7:0] pad_bits
	logic [1:0]  m_axis_tuser;  // [0] changed, [1] accepted

	hid_gamepad_report_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shared between stimulus, driver and monitor
	hid_byte_t   pend_q[$];
	pad_result_t expected_masks[$];
	int          errors = 0;
	int          items_in = 0;
	int          items_queued = 0;
	bit          in_taken = 1'b0;
	bit          calm = 1'b0;

	// decoder shadow: layout registers and per-report state
	cfg_t        cfg;
	logic [8:0]  pos_cnt;
	logic [7:0]  cap_x, cap_y, cap_dpad, cap_btn_lo, cap_btn_hi;
	logic [7:0]  pad_now;

	task automatic note_failure(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		errors++;
	endtask

	function automatic logic [7:0] axis_dirs(input logic [7:0] v, input logic [7:0] neg,
			input logic [7:0] pos);
		if (v < AXIS_LO)
			return neg;
		if (v > AXIS_HI)
			return pos;
		return 8'h00;
	endfunction

	// hat: 0..7 clockwise from up, everything else centered
	function automatic logic [7:0] hat_to_dirs(input logic [3:0] h);
		case (h)
			4'd0: return DIR_UP;
			4'd1: return DIR_UP | DIR_RIGHT;
			4'd2: return DIR_RIGHT;
			4'd3: return DIR_DOWN | DIR_RIGHT;
			4'd4: return DIR_DOWN;
			4'd5: return DIR_DOWN | DIR_LEFT;
			4'd6: return DIR_LEFT;
			4'd7: return DIR_UP | DIR_LEFT;
			default: return 8'h00;
		endcase
	endfunction

	// mask for a finished report of len bytes, under the layout now in force
	function automatic logic [7:0] mask_for(input logic [8:0] len);
		logic [7:0] m;
		int i;
		m = 8'h00;
		case (cfg.dpad_mode)
			MODE_AXIS: begin
				if (len > cfg.x_offset && len > cfg.y_offset)
					m = axis_dirs(cap_x, DIR_LEFT, DIR_RIGHT) |
						axis_dirs(cap_y, DIR_UP, DIR_DOWN);
			end
			MODE_HAT: begin
				if (len > cfg.dpad_offset)
					m = hat_to_dirs(cap_dpad[3:0]);
			end
			MODE_DBIT: begin
				if (len > cfg.dpad_offset) begin
					if (cap_dpad[0]) m = m | DIR_UP;
					if (cap_dpad[1]) m = m | DIR_DOWN;
					if (cap_dpad[2]) m = m | DIR_LEFT;
					if (cap_dpad[3]) m = m | DIR_RIGHT;
				end
			end
			default: ;
		endcase
		if (int'(len) > int'(cfg.button_offset) + 1) begin
			for (i = 0; i < 8; i++) begin
				if (cap_btn_lo[i]) m = m | cfg.button_map_low[8*i +: 8];
				if (cap_btn_hi[i]) m = m | cfg.button_map_high[8*i +: 8];
			end
		end
		return m;
	endfunction

	// advance the shadow by one accepted byte; queue a result at report end
	function automatic void predict_byte(input hid_byte_t b);
		logic [8:0]  len;
		logic [7:0]  m;
		pad_result_t r;
		if (b.action) begin
			pad_now = 8'h00;
			pos_cnt = '0;
			return;
		end
		if (pos_cnt == cfg.x_offset) cap_x = b.data;
		if (pos_cnt == cfg.y_offset) cap_y = b.data;
		if (pos_cnt == cfg.dpad_offset) cap_dpad = b.data;
		if (pos_cnt == cfg.button_offset) cap_btn_lo = b.data;
		if (int'(pos_cnt) == int'(cfg.button_offset) + 1) cap_btn_hi = b.data;
		if (pos_cnt < CNT_MAX)
			pos_cnt = pos_cnt + 9'd1;
		if (!b.last)
			return;
		len = pos_cnt;
		pos_cnt = '0;
		if (cfg.id_filter != ANY_ID && b.rid != cfg.id_filter) begin
			r.pad_bits = pad_now;
			r.changed = 1'b0;
			r.accepted = 1'b0;
		end else begin
			m = mask_for(len);
			r.pad_bits = m;
			r.changed = (m != pad_now);
			r.accepted = 1'b1;
			pad_now = m;
		end
		expected_masks.push_back(r);
	endfunction

	// monitor: predict on input handshakes, check on output handshakes
	always @(posedge clk) begin : monitor
		hid_byte_t   b;
		pad_result_t want;
		in_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_taken) begin
			b.action = s_axis_tuser;
			b.data = s_axis_tdata[7:0];
			b.rid = s_axis_tdata[15:8];
			b.last = s_axis_tlast;
			predict_byte(b);
			items_in++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_masks.size() == 0) begin
				note_failure($sformatf("unexpected result pad_bits %02h", m_axis_tdata));
			end else begin
				want = expected_masks.pop_front();
				if (m_axis_tdata !== want.pad_bits)
					note_failure($sformatf("pad_bits %02h, want %02h", m_axis_tdata,
						want.pad_bits));
				if (m_axis_tuser[0] !== want.changed)
					note_failure($sformatf("changed %b, want %b", m_axis_tuser[0],
						want.changed));
				if (m_axis_tuser[1] !== want.accepted)
					note_failure($sformatf("accepted %b, want %b", m_axis_tuser[1],
						want.accepted));
			end
		end
	end

	// byte driver: holds an item until taken, random gap bursts
	int gap_left = 0;
	always @(negedge clk) begin : byte_driver
		hid_byte_t b;
		logic      v;
		if (!s_axis_tvalid || in_taken) begin
			v = 1'b0;
			b = '0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pend_q.size() == 0) begin
				v = 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				gap_left = $urandom_range(1, 10) - 1;
			end else begin
				b = pend_q.pop_front();
				v = 1'b1;
			end
			s_axis_tvalid <= v;
			if (v) begin
				s_axis_tdata <= {b.rid, b.data};
				s_axis_tlast <= b.last;
				s_axis_tuser <= b.action;
			end
		end
	end

	// result receiver: stall bursts plus one long hold-off while bytes keep coming
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(negedge clk) begin : mask_receiver
		logic rdy;
		rdy = 1'b0;
		if (hold_left > 0) begin
			hold_left--;
		end else if (!hold_done && items_in > 400 && pend_q.size() > 40) begin
			hold_done = 1'b1;
			hold_left = 299;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 10) - 1;
		end else begin
			rdy = 1'b1;
		end
		m_axis_tready <= rdy;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_DPAD_MODE:   cfg.dpad_mode = val[1:0];
			REG_DPAD_OFFSET: cfg.dpad_offset = val[3:0];
			REG_X_OFFSET:    cfg.x_offset = val[7:0];
			REG_Y_OFFSET:    cfg.y_offset = val[7:0];
			REG_BTN_OFFSET:  cfg.button_offset = val[3:0];
			REG_MAP_LOW:     cfg.button_map_low = val;
			REG_MAP_HIGH:    cfg.button_map_high = val;
			REG_ID_FILTER:   cfg.id_filter = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [63:0] pick_reg_value(input logic [2:0] idx);
		logic [63:0] v;
		int b;
		v = '0;
		case (idx)
			REG_DPAD_MODE:   v = 64'($urandom_range(0, 3));
			REG_DPAD_OFFSET: v = 64'($urandom_range(0, 15));
			REG_BTN_OFFSET:  v = 64'($urandom_range(0, 15));
			REG_X_OFFSET, REG_Y_OFFSET: begin
				if ($urandom_range(0, 7) == 0)
					v = 64'($urandom_range(0, 255));
				else
					v = 64'($urandom_range(0, 12));
			end
			REG_MAP_LOW, REG_MAP_HIGH: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = '1;
					2: for (b = 0; b < 8; b++) v[8*b +: 8] = 8'h01 << $urandom_range(0, 7);
					default: v = {$urandom, $urandom};
				endcase
			end
			REG_ID_FILTER: begin
				if ($urandom_range(0, 1) == 0)
					v = 64'(ANY_ID);
				else
					v = 64'($urandom_range(0, 254));
			end
			default: ;
		endcase
		return v;
	endfunction

	task automatic push_byte(input logic [7:0] data, input logic [7:0] rid, input logic last);
		hid_byte_t b;
		b.action = 1'b0;
		b.data = data;
		b.rid = rid;
		b.last = last;
		pend_q.push_back(b);
		items_queued++;
	endtask

	// connect/disconnect: other fields are don't-care, so randomize them
	task automatic push_link();
		hid_byte_t b;
		b.action = 1'b1;
		b.data = 8'($urandom);
		b.rid = 8'($urandom);
		b.last = 1'($urandom_range(0, 1));
		pend_q.push_back(b);
		items_queued++;
	endtask

	function automatic logic [7:0] pick_data();
		logic [7:0] marks[8];
		logic [7:0] d;
		marks = '{8'h00, 8'h3F, 8'h40, 8'h80, 8'hC0, 8'hC1, 8'hFF, 8'h0F};
		d = 8'($urandom);
		case ($urandom_range(0, 5))
			0: d = marks[$urandom_range(0, 7)];
			1: d[3:0] = 4'($urandom_range(0, 8));
			default: ;
		endcase
		return d;
	endfunction

	// one report; open ones are left for the next phase to finish
	task automatic gen_report(input int len, input bit finish);
		int i;
		logic [7:0] rid;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 49) == 0)
				push_link();
			rid = 8'($urandom);
			if (finish && i == len - 1) begin
				if (cfg.id_filter != ANY_ID && $urandom_range(0, 2) != 0)
					rid = cfg.id_filter;
				push_byte(pick_data(), rid, 1'b1);
			end else begin
				push_byte(pick_data(), rid, 1'b0);
			end
		end
	endtask

	function automatic int pick_len();
		int need;
		int r;
		need = int'(cfg.button_offset) + 2;
		if (cfg.dpad_mode == MODE_AXIS) begin
			if (int'(cfg.x_offset) + 1 > need) need = int'(cfg.x_offset) + 1;
			if (int'(cfg.y_offset) + 1 > need) need = int'(cfg.y_offset) + 1;
		end else if (int'(cfg.dpad_offset) + 1 > need) begin
			need = int'(cfg.dpad_offset) + 1;
		end
		r = $urandom_range(0, 99);
		if (r == 0)
			return $urandom_range(256, 262);
		if (r < 75)
			return need + $urandom_range(0, 3);
		return $urandom_range(1, need);
	endfunction

	// wait until every byte is taken and every result is back, then let the pipe settle
	task automatic drain();
		while (pend_q.size() != 0 || s_axis_tvalid || expected_masks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure_phase(input int ph);
		int k;
		logic [2:0] idx;
		if (ph == 0) begin
			write_reg(REG_DPAD_MODE, 64'(MODE_AXIS));
			write_reg(REG_DPAD_OFFSET, 64'd0);
			write_reg(REG_X_OFFSET, 64'd0);
			write_reg(REG_Y_OFFSET, 64'd0);
			write_reg(REG_BTN_OFFSET, 64'd0);
			write_reg(REG_MAP_LOW, 64'd0);
			write_reg(REG_MAP_HIGH, 64'd0);
			write_reg(REG_ID_FILTER, 64'd0);
		end else if (ph == 1) begin
			write_reg(REG_DPAD_MODE, 64'(MODE_NONE));
			write_reg(REG_DPAD_OFFSET, 64'd15);
			write_reg(REG_X_OFFSET, 64'd255);
			write_reg(REG_Y_OFFSET, 64'd255);
			write_reg(REG_BTN_OFFSET, 64'd15);
			write_reg(REG_MAP_LOW, '1);
			write_reg(REG_MAP_HIGH, '1);
			write_reg(REG_ID_FILTER, 64'(ANY_ID));
		end else begin
			for (k = 0; k < 8; k++) begin
				idx = 3'(k);
				if (ph == 2 || $urandom_range(0, 2) == 0)
					write_reg(idx, pick_reg_value(idx));
			end
		end
	endtask

	initial begin : stimulus
		int ph;
		int budget;
		cfg.dpad_mode = MODE_HAT;
		cfg.dpad_offset = 4'd1;
		cfg.x_offset = 8'd0;
		cfg.y_offset = 8'd0;
		cfg.button_offset = 4'd2;
		cfg.button_map_low = 64'h0000_0000_0202_0104;
		cfg.button_map_high = 64'h0000_0000_0800_0000;
		cfg.id_filter = ANY_ID;
		pos_cnt = '0;
		{cap_x, cap_y, cap_dpad, cap_btn_lo, cap_btn_hi} = '0;
		pad_now = 8'h00;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default layout: first report fills every captured byte
		push_byte(8'h00, 8'h00, 1'b0);
		push_byte(8'h00, 8'h00, 1'b0);
		push_byte(8'h01, 8'h00, 1'b0);
		push_byte(8'h80, 8'h00, 1'b1);
		push_link();
		// hat out of range, all buttons
		push_byte(8'hFF, 8'h00, 1'b0);
		push_byte(8'h08, 8'h00, 1'b0);
		push_byte(8'hFF, 8'h00, 1'b0);
		push_byte(8'hFF, 8'hFF, 1'b1);
		// too short to reach the buttons
		push_byte(8'h12, 8'h00, 1'b0);
		push_byte(8'hF7, 8'hA5, 1'b1);
		// disconnect in the middle of a report
		push_byte(8'h55, 8'h00, 1'b0);
		push_link();
		drain();

		// axis mode at the deadzone edges, then a rejected ID
		write_reg(REG_DPAD_MODE, 64'(MODE_AXIS));
		write_reg(REG_Y_OFFSET, 64'd1);
		write_reg(REG_ID_FILTER, 64'h5A);
		push_byte(8'h3F, 8'h00, 1'b0);
		push_byte(8'hC1, 8'h5A, 1'b1);
		push_byte(8'h40, 8'h00, 1'b0);
		push_byte(8'hC0, 8'h5A, 1'b1);
		push_byte(8'h00, 8'h00, 1'b0);
		push_byte(8'hFF, 8'h00, 1'b1);
		drain();

		// no direction mode; then leave a report open across a layout change
		write_reg(REG_DPAD_MODE, 64'(MODE_NONE));
		write_reg(REG_ID_FILTER, 64'(ANY_ID));
		push_byte(8'h00, 8'h00, 1'b0);
		push_byte(8'h00, 8'h00, 1'b0);
		push_byte(8'hFF, 8'h00, 1'b0);
		push_byte(8'hFF, 8'h33, 1'b1);
		push_byte(8'hAA, 8'h00, 1'b0);
		push_byte(8'hAA, 8'h00, 1'b0);
		drain();
		write_reg(REG_DPAD_MODE, 64'(MODE_DBIT));
		write_reg(REG_DPAD_OFFSET, 64'd2);
		push_byte(8'h0F, 8'h00, 1'b0);
		push_byte(8'hFF, 8'h00, 1'b0);
		push_byte(8'h00, 8'h00, 1'b1);
		drain();

		// random phases, each under its own layout
		for (ph = 0; ph < PHASES; ph++) begin
			configure_phase(ph);
			calm = (ph >= CALM_FROM);
			budget = items_queued + PHASE_ITEMS;
			while (items_queued < budget)
				gen_report(pick_len(), 1'b1);
			if ($urandom_range(0, 2) == 0)
				gen_report($urandom_range(1, 4), 1'b0);
			drain();
		end

		repeat (6) @(posedge clk);
		if (errors == 0 && expected_masks.size() == 0) begin
			$display("[hid_gamepad_report_decoder] OK");
		end else begin
			$display("[hid_gamepad_report_decoder] ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("[hid_gamepad_report_decoder] ERROR");
		$finish;
	end

endmodule

// File: hid_gamepad_report_decoder.f
+incdir+sv
sv/hgrd_pkg.sv
sv/hgrd_cfg.sv
sv/hgrd_core.sv
sv/hid_gamepad_report_decoder.sv
tb/sv/hid_gamepad_report_decoder_tb.sv
